// File: rtl/png_scanline_unfilter_defines.svh
// Assertion macros for the PNG scanline unfilter.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define PUS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PUS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PUS_ASSERT(label, prop, msg)
`define PUS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: rtl/pus_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// No dependencies.
`default_nettype none

package pus_pkg;

    localparam int ROW_MAX_DEF = 8192;
    localparam int CFG_LEN_W   = 14;
    localparam int CFG_BPP_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW = 1'b1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    localparam logic [7:0] FILT_LAST_CODE = 8'd4;

endpackage

`default_nettype wire

// File: rtl/pus_linebuf.sv
// Prior-row line buffer: one write port, one registered read port.
// Depends on nothing beyond its parameter.
`default_nettype none

module pus_linebuf #(
    parameter int ROW_MAX = 8192
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(ROW_MAX)-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(ROW_MAX)-1:0] rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [ROW_MAX];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/pus_predict.sv
// Filter predictor: None, Sub, Up, Average and Paeth from left, up, up-left.
// Depends on pus_pkg.
`default_nettype none

module pus_predict
    import pus_pkg::*;
(
    input  filt_t      kind,
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic [7:0] c,
    output logic [7:0] pred
);

    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [9:0]        pa_abs;
    logic [9:0]        pb_abs;
    logic [9:0]        pc_abs;
    logic [8:0]        sum_ab;
    logic [7:0]        paeth;

    always_comb
    begin
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        pa     = $signed({2'b00, b}) - $signed({2'b00, c});
        pb     = $signed({2'b00, a}) - $signed({2'b00, c});
        pc     = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa_abs = pa[9] ? 10'(-pa) : 10'(pa);
        pb_abs = pb[9] ? 10'(-pb) : 10'(pb);
        pc_abs = pc[9] ? 10'(-pc) : 10'(pc);
        sum_ab = {1'b0, a} + {1'b0, b};

        priority if (pa_abs <= pb_abs && pa_abs <= pc_abs)
        begin
            paeth = a;
        end
        else if (pb_abs <= pc_abs)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end

        unique case (kind)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter, top level: input stage, row control, output register.
// Depends on pus_pkg, pus_linebuf, pus_predict and png_scanline_unfilter_defines.svh.
//
// Takes one inflated byte per transfer and returns one reconstructed byte per
// sample, one transfer per cycle sustained while m_tready holds: an accepted
// byte sits in the input stage while the line buffer read for its column
// completes, then the predictor and adder write the output register. Valid
// filter-type bytes and bytes dropped after a bad filter give no output
// transfer. tlast marks the last byte of a row; tuser marks a bad filter
// type, after which bytes are dropped until one arrives with s_tuser set.
// Write configuration only while no byte is in flight.
`default_nettype none

module png_scanline_unfilter
    import pus_pkg::*;
#(
    parameter int ROW_MAX = ROW_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] first_of_image
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] pixel_byte
    output logic                  m_tlast,
    output logic                  m_tuser    // [0] bad_filter
);

    localparam int AW    = $clog2(ROW_MAX);
    localparam int RM_W  = $clog2(ROW_MAX + 1);
    localparam int LEN_W = (CFG_LEN_W > RM_W) ? CFG_LEN_W : RM_W;

    logic [CFG_BPP_W-1:0] bpp_reg;
    logic [CFG_LEN_W-1:0] row_bytes_reg;

    logic [AW-1:0] column_reg,    column_next;
    logic [23:0]   left_reg,      left_next;
    logic [23:0]   upleft_reg,    upleft_next;
    filt_t         kind_reg,      kind_next;
    logic          first_row_reg, first_row_next;
    logic          row_start_reg, row_start_next;
    logic          halted_reg,    halted_next;

    logic          stg_valid_reg;
    logic [7:0]    stg_data_reg;
    logic          stg_first_reg;

    logic          out_valid_reg;
    logic [7:0]    out_pixel_reg;
    logic          out_last_reg;
    logic          out_bad_reg;

    logic [LEN_W-1:0] len_eff;
    logic [AW-1:0]    col_eff;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic [7:0]       a_byte;
    logic [7:0]       b_byte;
    logic [7:0]       c_byte;
    logic [7:0]       pred;
    logic [7:0]       val;
    logic             has_result;
    logic             is_sample;
    logic             advance;
    logic             res_last;
    logic             res_bad;
    logic             in_xfer;

    function automatic logic [AW-1:0] clamp_col(input logic [AW-1:0] col,
                                                input logic [LEN_W-1:0] len);
        logic [AW-1:0] r;
        if (LEN_W'(col) >= len)
        begin
            r = AW'(len - LEN_W'(1));
        end
        else
        begin
            r = col;
        end
        return r;
    endfunction

    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(row_bytes_reg) > LEN_W'(ROW_MAX))
        begin
            len_eff = LEN_W'(ROW_MAX);
        end
        else
        begin
            len_eff = LEN_W'(row_bytes_reg);
        end
    end

    assign col_eff = clamp_col(column_reg, len_eff);

    always_comb
    begin
        unique case (bpp_reg)
            2'd2:
            begin
                a_byte = left_reg[15:8];
                c_byte = upleft_reg[15:8];
            end
            2'd3:
            begin
                a_byte = left_reg[23:16];
                c_byte = upleft_reg[23:16];
            end
            default:
            begin
                a_byte = left_reg[7:0];
                c_byte = upleft_reg[7:0];
            end
        endcase
    end

    assign b_byte = (stg_first_reg || first_row_reg) ? 8'd0 : rd_data;

    pus_predict u_predict (
        .kind (kind_reg),
        .a    (a_byte),
        .b    (b_byte),
        .c    (c_byte),
        .pred (pred)
    );

    always_comb
    begin
        logic             halted_eff;
        logic             first_row_eff;
        logic             row_start_eff;
        logic [LEN_W-1:0] col_inc;

        halted_eff    = stg_first_reg ? 1'b0 : halted_reg;
        first_row_eff = stg_first_reg ? 1'b1 : first_row_reg;
        row_start_eff = stg_first_reg ? 1'b1 : row_start_reg;
        col_inc       = LEN_W'(col_eff) + LEN_W'(1);

        val    = stg_data_reg + pred;

        has_result = 1'b0;
        is_sample  = 1'b0;
        res_last   = 1'b0;
        res_bad    = 1'b0;

        column_next    = column_reg;
        left_next      = left_reg;
        upleft_next    = upleft_reg;
        kind_next      = kind_reg;
        first_row_next = first_row_eff;
        row_start_next = row_start_eff;
        halted_next    = halted_eff;

        priority if (halted_eff)
        begin
            has_result = 1'b0;
        end
        else if (row_start_eff)
        begin
            if (stg_data_reg > FILT_LAST_CODE)
            begin
                has_result  = 1'b1;
                res_bad     = 1'b1;
                halted_next = 1'b1;
            end
            else
            begin
                kind_next      = filt_t'(stg_data_reg[2:0]);
                row_start_next = 1'b0;
                column_next    = '0;
                left_next      = '0;
                upleft_next    = '0;
            end
        end
        else
        begin
            has_result  = 1'b1;
            is_sample   = 1'b1;
            left_next   = {left_reg[15:0], val};
            upleft_next = {upleft_reg[15:0], b_byte};
            if (col_inc >= len_eff)
            begin
                res_last       = 1'b1;
                column_next    = '0;
                row_start_next = 1'b1;
                first_row_next = 1'b0;
            end
            else
            begin
                column_next = AW'(col_inc);
            end
        end

        advance = stg_valid_reg && (!has_result || !out_valid_reg || m_tready);

        if (!advance)
        begin
            column_next    = column_reg;
            left_next      = left_reg;
            upleft_next    = upleft_reg;
            kind_next      = kind_reg;
            first_row_next = first_row_reg;
            row_start_next = row_start_reg;
            halted_next    = halted_reg;
        end
    end

    assign s_tready = !stg_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;
    assign rd_addr  = clamp_col(column_next, len_eff);

    pus_linebuf #(
        .ROW_MAX (ROW_MAX)
    ) u_linebuf (
        .clk     (clk),
        .wr_en   (advance && is_sample),
        .wr_addr (col_eff),
        .wr_data (val),
        .rd_en   (in_xfer),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= CFG_BPP_W'(1);
            row_bytes_reg <= CFG_LEN_W'(1);
            column_reg    <= '0;
            left_reg      <= '0;
            upleft_reg    <= '0;
            kind_reg      <= FILT_NONE;
            first_row_reg <= 1'b1;
            row_start_reg <= 1'b1;
            halted_reg    <= 1'b0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_IDX_BPP: bpp_reg       <= cfg_data[CFG_BPP_W-1:0];
                    CFG_IDX_ROW: row_bytes_reg <= cfg_data[CFG_LEN_W-1:0];
                    default:     bpp_reg       <= bpp_reg;
                endcase
            end
            column_reg    <= column_next;
            left_reg      <= left_next;
            upleft_reg    <= upleft_next;
            kind_reg      <= kind_next;
            first_row_reg <= first_row_next;
            row_start_reg <= row_start_next;
            halted_reg    <= halted_next;
            if (in_xfer)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_data_reg  <= s_tdata;
            stg_first_reg <= s_tuser;
        end
        if (advance && has_result)
        begin
            out_pixel_reg <= res_bad ? 8'd0 : val;
            out_last_reg  <= res_last;
            out_bad_reg   <= res_bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

`include "png_scanline_unfilter_defines.svh"

    `PUS_ASSERT(a_bad_clean, out_valid_reg && out_bad_reg |-> out_pixel_reg == 8'd0 && !out_last_reg, "bad filter transfer carries data")
    `PUS_ASSERT(a_stall_src, !s_tready |-> stg_valid_reg && out_valid_reg && !m_tready, "input stalled without a full pipeline")
    `PUS_ASSERT_NEVER(a_halt_write, halted_reg && stg_valid_reg && !stg_first_reg && advance && is_sample, "line buffer written while halted")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for png_scanline_unfilter: directed and random PNG row streams.
// Predicts each reconstructed byte in-line and checks the output stream under random stalls.
// Depends on pus_pkg and the png_scanline_unfilter RTL.
`timescale 1ns / 100ps

module tb_top;
    import pus_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       bad_filter;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // unfilter state mirrored from the spec
    logic [7:0]            line_mem [ROW_MAX_DEF];
    logic [23:0]           left_hist;
    logic [23:0]           above_hist;
    int unsigned           col;
    filt_t                 cur_filt;
    bit                    first_row;
    bit                    row_start;
    bit                    stopped;
    logic [CFG_BPP_W-1:0]  cfg_bpp;
    logic [CFG_LEN_W-1:0]  cfg_len;

    pixel_t                expected_pixels [$];
    int                    mismatch_count;
    int                    samples_sent;
    int                    src_idle_pct;
    int                    snk_idle_pct;
    int                    sink_hold_left;
    int                    stall_cycles;

    png_scanline_unfilter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic unfilter_byte(input logic [7:0] x, input logic first);
        int unsigned bpp;
        int unsigned len;
        int unsigned sh;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  pred;
        logic [7:0]  val;
        pixel_t      px;
        if (first)
        begin
            stopped   = 1'b0;
            first_row = 1'b1;
            row_start = 1'b1;
        end
        if (stopped)
            return;
        if (row_start)
        begin
            if (x > FILT_LAST_CODE)
            begin
                stopped = 1'b1;
                px = '{pixel_byte: 8'h00, row_end: 1'b0, bad_filter: 1'b1};
                expected_pixels.push_back(px);
                return;
            end
            cur_filt   = filt_t'(x[2:0]);
            row_start  = 1'b0;
            col        = 0;
            left_hist  = '0;
            above_hist = '0;
            return;
        end
        bpp = (cfg_bpp == 0) ? 1 : cfg_bpp;
        len = (cfg_len == 0) ? 1 : cfg_len;
        if (len > ROW_MAX_DEF)
            len = ROW_MAX_DEF;
        if (col >= len)
            col = len - 1;
        sh = 8 * (bpp - 1);
        a  = left_hist[sh +: 8];
        c  = above_hist[sh +: 8];
        b  = first_row ? 8'h00 : line_mem[col];
        case (cur_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'h00;
        endcase
        val           = x + pred;
        line_mem[col] = val;
        left_hist     = {left_hist[15:0], val};
        above_hist    = {above_hist[15:0], b};
        col++;
        px = '{pixel_byte: val, row_end: 1'b0, bad_filter: 1'b0};
        if (col >= len)
        begin
            px.row_end = 1'b1;
            col        = 0;
            row_start  = 1'b1;
            first_row  = 1'b0;
        end
        expected_pixels.push_back(px);
    endtask

    task automatic send_byte(input logic [7:0] d, input logic first);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        unfilter_byte(d, first);
    endtask

    task automatic send_row4(input logic [7:0] filt, input logic first, input logic [31:0] s);
        send_byte(filt, first);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(s[8*i +: 8], 1'b0);
            samples_sent++;
        end
    endtask

    task automatic send_samples(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'($urandom), 1'b0);
            samples_sent++;
        end
    endtask

    // valid filter-type bytes leave no output, so allow for bytes still in the pipe
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_BPP_W-1:0] bpp, input logic [CFG_LEN_W-1:0] len);
        wait_drain();
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_IDX_BPP;
        cfg_data  <= CFG_DATA_W'(bpp);
        @(posedge clk);
        cfg_index <= CFG_IDX_ROW;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        cfg_bpp   = bpp;
        cfg_len   = len;
    endtask

    task automatic test_filters();
        set_config(2'd1, 14'd4);
        send_row4(8'(FILT_NONE),  1'b1, 32'h01_80_FF_00);
        send_row4(8'(FILT_SUB),   1'b0, 32'h7F_00_01_FF);
        send_row4(8'(FILT_UP),    1'b0, 32'h80_00_FF_FF);
        send_row4(8'(FILT_AVG),   1'b0, 32'h00_FF_FE_01);
        send_row4(8'(FILT_PAETH), 1'b0, 32'h37_C8_00_00);
    endtask

    task automatic test_bad_filter();
        set_config(2'd2, 14'd4);
        send_row4(8'(FILT_NONE), 1'b1, 32'hA5_5A_0F_F0);
        send_byte(FILT_LAST_CODE + 8'd1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'(FILT_SUB), 1'b1);
        send_samples(2);
        // new image starts in the middle of a row
        send_byte(8'(FILT_AVG), 1'b1);
        send_samples(4);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC8, 1'b1);
        send_row4(8'(FILT_PAETH), 1'b1, 32'hFF_10_80_7F);
    endtask

    task automatic test_config_edges();
        set_config(2'd0, 14'd0);
        send_byte(8'(FILT_NONE), 1'b1);
        send_samples(1);
        send_byte(8'(FILT_SUB), 1'b0);
        send_samples(1);
        send_byte(8'(FILT_UP), 1'b0);
        send_samples(1);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_samples(1);
        send_byte(8'(FILT_AVG), 1'b0);
        send_samples(1);
        set_config(2'd3, 14'd8);
        send_byte(8'(FILT_SUB), 1'b1);
        send_samples(8);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_samples(5);
        // row length shrinks below the current column
        set_config(2'd3, 14'd3);
        send_samples(1);
        send_byte(8'(FILT_UP), 1'b0);
        send_samples(3);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_samples(3);
    endtask

    // row length above the buffer depth; only the start of the row is sent
    task automatic test_long_row();
        set_config(2'd2, 14'h3FFF);
        send_byte(8'(FILT_NONE), 1'b1);
        send_samples(24);
    endtask

    task automatic test_backpressure();
        set_config(2'd3, 14'd8);
        sink_hold_left = 300;
        send_byte(8'(FILT_SUB), 1'b1);
        send_samples(8);
        send_byte(8'(FILT_AVG), 1'b0);
        send_samples(8);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_samples(8);
    endtask

    task automatic send_random_image();
        int rows;
        int len;
        bit fresh;
        rows  = $urandom_range(1, 6);
        len   = (cfg_len == 0) ? 1 : cfg_len;
        fresh = 1'b1;
        for (int r = 0; r < rows; r++)
        begin
            if ($urandom_range(99) < 4)
            begin
                send_byte(8'($urandom_range(5, 255)), fresh);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
                return;
            end
            send_byte(8'($urandom_range(0, 4)), fresh);
            fresh = 1'b0;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 2)
                begin
                    fresh = 1'b1;
                    break;
                end
                send_byte(8'($urandom), 1'b0);
                samples_sent++;
            end
        end
    endtask

    task automatic test_random(input int n);
        int target;
        int pick;
        logic [CFG_LEN_W-1:0] len;
        target = samples_sent + n;
        while (samples_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                len = '0;
            else if (pick < 85)
                len = CFG_LEN_W'($urandom_range(1, 12));
            else
                len = CFG_LEN_W'($urandom_range(13, 48));
            set_config(CFG_BPP_W'($urandom_range(0, 3)), len);
            repeat ($urandom_range(1, 3)) send_random_image();
        end
    endtask

    always @(posedge clk)
    begin : sink
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected transfer data %h last %b user %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.pixel_byte)
                begin
                    $display("%0t: pixel_byte expected %h actual %h",
                             $time, want.pixel_byte, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.row_end)
                begin
                    $display("%0t: row_end expected %b actual %b", $time, want.row_end, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.bad_filter)
                begin
                    $display("%0t: bad_filter expected %b actual %b",
                             $time, want.bad_filter, m_tuser);
                    mismatch_count++;
                end
            end
        end
        if (sink_hold_left > 0)
        begin
            sink_hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_wen        <= 1'b0;
        cfg_index      <= CFG_IDX_BPP;
        cfg_data       <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= 1'b0;
        m_tready       <= 1'b0;
        mismatch_count = 0;
        samples_sent   = 0;
        sink_hold_left = 0;
        stall_cycles   = 0;
        src_idle_pct   = 17;
        snk_idle_pct   = 61;
        for (int i = 0; i < ROW_MAX_DEF; i++)
            line_mem[i] = '0;
        left_hist  = '0;
        above_hist = '0;
        col        = 0;
        cur_filt   = FILT_NONE;
        first_row  = 1'b1;
        row_start  = 1'b1;
        stopped    = 1'b0;
        cfg_bpp    = 2'd1;
        cfg_len    = 14'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_filters();
        test_bad_filter();
        test_config_edges();
        test_random(80);

        src_idle_pct = 61;
        snk_idle_pct = 17;
        test_random(80);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_backpressure();
        test_long_row();
        test_random(80);

        wait_drain();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pus_pkg.sv
rtl/pus_linebuf.sv
rtl/pus_predict.sv
rtl/png_scanline_unfilter.sv
tb/tb_top.sv
